FILE: hdl/lupa_pkg.sv
// lupa_pkg: shared constants, payload types and controller/datapath command types
// for the least used port allocator; no dependencies
`default_nettype none

package lupa_pkg;

	localparam int NUM_PORTS    = 65536;
	localparam int DYNAMIC_BASE = 32768;
	localparam int MAX_BUCKET   = 65535;

	localparam int PORT_W = 16;
	localparam int CNT_W  = 17;
	localparam logic [CNT_W-1:0] COUNT_LIMIT = '1;

	localparam int NUM_BUCKETS = MAX_BUCKET + 1;
	localparam int MAP_WORDS   = (NUM_BUCKETS + 63) / 64;
	localparam int SUM_WORDS   = (MAP_WORDS + 63) / 64;

	localparam int PA_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
	localparam int BK_W = $clog2(NUM_BUCKETS);
	localparam int MW_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int SW_W = (SUM_WORDS > 1) ? $clog2(SUM_WORDS) : 1;

	localparam int CLR_LEN = (NUM_PORTS > MAP_WORDS) ? NUM_PORTS : MAP_WORDS;
	localparam int CLR_W   = $clog2(CLR_LEN);

	localparam bit HAS_AVAIL = DYNAMIC_BASE < NUM_PORTS;

	typedef struct packed {
		logic [1:0]        action;
		logic [PORT_W-1:0] port_number;
	} req_t;

	typedef struct packed {
		logic [PORT_W-1:0] granted_port;
		logic [1:0]        status;
		logic              took_preferred;
	} rsp_t;

	typedef enum logic [1:0] {
		ACT_GET     = 2'd0,
		ACT_ALLOC   = 2'd1,
		ACT_DEALLOC = 2'd2,
		ACT_RSVD    = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ZERO  = 2'd1,
		ST_LIMIT = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_ACCEPT,
		OP_RD_CNT,
		OP_EVAL,
		OP_SRCH1,
		OP_SRCH2,
		OP_SRCH3,
		OP_SRCH4,
		OP_UNL_RD,
		OP_UNL_WR,
		OP_CNT_WR,
		OP_APP_RD,
		OP_APP_WR,
		OP_DONE
	} op_t;

	typedef struct packed {
		op_t     op;
		logic    dec;
		status_t status;
		logic    took;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic in_range;
		logic avail;
		logic cnt_zero;
		logic cnt_lim;
		logic unl_need;
		logic app_need;
	} stat_t;

endpackage

`default_nettype wire

FILE: hdl/lupa_ram.sv
// lupa_ram: generic single-port ram with registered read
// no dependencies
`default_nettype none

module lupa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/lupa_datapath.sv
// lupa_datapath: count, link and bucket memories, bucket bitmap summary,
// search logic and result register; uses lupa_pkg and lupa_ram
`default_nettype none

module lupa_datapath (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire lupa_pkg::cmd_t  cmd,
	input  wire lupa_pkg::req_t  req,
	output lupa_pkg::stat_t      stat,
	output lupa_pkg::rsp_t       rsp
);

	localparam int PW = lupa_pkg::PORT_W;
	localparam int CW = lupa_pkg::CNT_W;
	localparam int SB = lupa_pkg::SUM_WORDS * 64;

	function automatic logic [5:0] lowest_bit(input logic [63:0] v);
		logic [5:0] n;
		n = 6'd63;
		for (int i = 63; i >= 0; i--) begin
			if (v[i]) n = 6'(i);
		end
		return n;
	endfunction

	logic [PW-1:0]             p_q;
	logic [CW-1:0]             c_old_q;
	logic [CW-1:0]             c_new_q;
	logic [lupa_pkg::SW_W-1:0] w_q;
	logic                      any_q;
	logic [lupa_pkg::MW_W-1:0] mw_q;
	logic [lupa_pkg::CLR_W-1:0] clr_q;
	logic [SB-1:0]             summ_q;
	lupa_pkg::rsp_t            rsp_q;

	// ram ports
	logic                      cnt_en, cnt_we;
	logic [lupa_pkg::PA_W-1:0] cnt_addr;
	logic [CW-1:0]             cnt_wdata, cnt_rdata;
	logic                      nxt_en, nxt_we;
	logic [lupa_pkg::PA_W-1:0] nxt_addr;
	logic [PW-1:0]             nxt_wdata, nxt_rdata;
	logic                      prv_en, prv_we;
	logic [lupa_pkg::PA_W-1:0] prv_addr;
	logic [PW-1:0]             prv_wdata, prv_rdata;
	logic                      head_en, head_we;
	logic [lupa_pkg::BK_W-1:0] head_addr;
	logic [PW-1:0]             head_wdata, head_rdata;
	logic                      tail_en, tail_we;
	logic [lupa_pkg::BK_W-1:0] tail_addr;
	logic [PW-1:0]             tail_wdata, tail_rdata;
	logic                      map_en, map_we;
	logic [lupa_pkg::MW_W-1:0] map_addr;
	logic [63:0]               map_wdata, map_rdata;

	logic [31:0]               idx32;
	logic [31:0]               p32;
	logic [lupa_pkg::MW_W-1:0] wo_old, wo_new;
	logic                      is_head, is_tail, both;
	logic [63:0]               map_clr, map_set;
	logic                      bkt_set;
	logic [lupa_pkg::SUM_WORDS-1:0] sflag;
	logic [lupa_pkg::SW_W-1:0] w_pick;
	logic                      w_any;
	logic [31:0]               mw32, b32;
	logic [31:0]               wo_old32, wo_new32;

	assign idx32    = 32'(clr_q);
	assign p32      = 32'(p_q);
	assign wo_old32 = 32'(c_old_q) >> 6;
	assign wo_new32 = 32'(c_new_q) >> 6;
	assign wo_old   = wo_old32[lupa_pkg::MW_W-1:0];
	assign wo_new   = wo_new32[lupa_pkg::MW_W-1:0];
	assign is_head  = head_rdata == p_q;
	assign is_tail  = tail_rdata == p_q;
	assign both     = is_head && is_tail;
	assign map_clr  = map_rdata & ~(64'd1 << c_old_q[5:0]);
	assign map_set  = map_rdata | (64'd1 << c_new_q[5:0]);
	assign bkt_set  = map_rdata[c_new_q[5:0]];
	assign mw32     = 32'({w_q, lowest_bit(summ_q[{w_q, 6'b0} +: 64])});
	assign b32      = 32'({mw_q, lowest_bit(map_rdata)});

	always_comb begin
		w_pick = '0;
		w_any  = 1'b0;
		for (int i = lupa_pkg::SUM_WORDS - 1; i >= 0; i--) begin
			sflag[i] = |summ_q[i*64 +: 64];
			if (sflag[i]) begin
				w_pick = lupa_pkg::SW_W'(i);
				w_any  = 1'b1;
			end
		end
	end

	always_comb begin
		stat.clr_last = clr_q == lupa_pkg::CLR_W'(lupa_pkg::CLR_LEN - 1);
		stat.in_range = p32 < lupa_pkg::NUM_PORTS;
		stat.avail    = (p32 >= lupa_pkg::DYNAMIC_BASE) && (p32 < lupa_pkg::NUM_PORTS);
		stat.cnt_zero = cnt_rdata == '0;
		stat.cnt_lim  = cnt_rdata == lupa_pkg::COUNT_LIMIT;
		stat.unl_need = stat.avail && (32'(c_old_q) <= lupa_pkg::MAX_BUCKET);
		stat.app_need = stat.avail && (32'(c_new_q) <= lupa_pkg::MAX_BUCKET);
	end

	// memory control per command
	always_comb begin
		cnt_en = 1'b0;  cnt_we = 1'b0;  cnt_addr = p_q[lupa_pkg::PA_W-1:0];
		cnt_wdata = c_new_q;
		nxt_en = 1'b0;  nxt_we = 1'b0;  nxt_addr = p_q[lupa_pkg::PA_W-1:0];
		nxt_wdata = nxt_rdata;
		prv_en = 1'b0;  prv_we = 1'b0;  prv_addr = p_q[lupa_pkg::PA_W-1:0];
		prv_wdata = prv_rdata;
		head_en = 1'b0; head_we = 1'b0; head_addr = c_old_q[lupa_pkg::BK_W-1:0];
		head_wdata = nxt_rdata;
		tail_en = 1'b0; tail_we = 1'b0; tail_addr = c_old_q[lupa_pkg::BK_W-1:0];
		tail_wdata = prv_rdata;
		map_en = 1'b0;  map_we = 1'b0;  map_addr = wo_old;
		map_wdata = map_clr;
		case (cmd.op)
			lupa_pkg::OP_CLEAR: begin
				cnt_en    = idx32 < lupa_pkg::NUM_PORTS;
				cnt_we    = 1'b1;
				cnt_addr  = clr_q[lupa_pkg::PA_W-1:0];
				cnt_wdata = '0;
				nxt_en    = (idx32 >= lupa_pkg::DYNAMIC_BASE)
					&& (idx32 + 32'd1 < lupa_pkg::NUM_PORTS);
				nxt_we    = 1'b1;
				nxt_addr  = clr_q[lupa_pkg::PA_W-1:0];
				nxt_wdata = PW'(idx32 + 32'd1);
				prv_en    = (idx32 > lupa_pkg::DYNAMIC_BASE)
					&& (idx32 < lupa_pkg::NUM_PORTS);
				prv_we    = 1'b1;
				prv_addr  = clr_q[lupa_pkg::PA_W-1:0];
				prv_wdata = PW'(idx32 - 32'd1);
				head_en    = (idx32 == 32'd0) && lupa_pkg::HAS_AVAIL;
				head_we    = 1'b1;
				head_addr  = '0;
				head_wdata = PW'(lupa_pkg::DYNAMIC_BASE);
				tail_en    = (idx32 == 32'd0) && lupa_pkg::HAS_AVAIL;
				tail_we    = 1'b1;
				tail_addr  = '0;
				tail_wdata = PW'(lupa_pkg::NUM_PORTS - 1);
				map_en    = idx32 < lupa_pkg::MAP_WORDS;
				map_we    = 1'b1;
				map_addr  = clr_q[lupa_pkg::MW_W-1:0];
				map_wdata = ((idx32 == 32'd0) && lupa_pkg::HAS_AVAIL) ? 64'd1 : 64'd0;
			end
			lupa_pkg::OP_RD_CNT: begin
				cnt_en = 1'b1;
			end
			lupa_pkg::OP_SRCH2: begin
				map_en   = 1'b1;
				map_addr = mw32[lupa_pkg::MW_W-1:0];
			end
			lupa_pkg::OP_SRCH3: begin
				head_en   = 1'b1;
				head_addr = b32[lupa_pkg::BK_W-1:0];
			end
			lupa_pkg::OP_UNL_RD: begin
				nxt_en  = 1'b1;
				prv_en  = 1'b1;
				head_en = 1'b1;
				tail_en = 1'b1;
				map_en  = 1'b1;
			end
			lupa_pkg::OP_UNL_WR: begin
				cnt_en = 1'b1;
				cnt_we = 1'b1;
				// single entry: bucket becomes empty
				map_en = both;
				map_we = 1'b1;
				// head moves on, or predecessor skips over the port
				head_en   = !both && is_head;
				head_we   = 1'b1;
				nxt_en    = !both && !is_head;
				nxt_we    = 1'b1;
				nxt_addr  = prv_rdata[lupa_pkg::PA_W-1:0];
				nxt_wdata = nxt_rdata;
				// tail moves back, or successor skips over the port
				tail_en   = !both && is_tail;
				tail_we   = 1'b1;
				prv_en    = !both && !is_tail;
				prv_we    = 1'b1;
				prv_addr  = nxt_rdata[lupa_pkg::PA_W-1:0];
				prv_wdata = prv_rdata;
			end
			lupa_pkg::OP_CNT_WR: begin
				cnt_en = 1'b1;
				cnt_we = 1'b1;
			end
			lupa_pkg::OP_APP_RD: begin
				map_en    = 1'b1;
				map_addr  = wo_new;
				tail_en   = 1'b1;
				tail_addr = c_new_q[lupa_pkg::BK_W-1:0];
			end
			lupa_pkg::OP_APP_WR: begin
				tail_en    = 1'b1;
				tail_we    = 1'b1;
				tail_addr  = c_new_q[lupa_pkg::BK_W-1:0];
				tail_wdata = p_q;
				// empty bucket: port becomes head and bucket is marked
				head_en    = !bkt_set;
				head_we    = 1'b1;
				head_addr  = c_new_q[lupa_pkg::BK_W-1:0];
				head_wdata = p_q;
				map_en     = !bkt_set;
				map_we     = 1'b1;
				map_addr   = wo_new;
				map_wdata  = map_set;
				// otherwise link behind the old tail
				nxt_en     = bkt_set;
				nxt_we     = 1'b1;
				nxt_addr   = tail_rdata[lupa_pkg::PA_W-1:0];
				nxt_wdata  = p_q;
				prv_en     = bkt_set;
				prv_we     = 1'b1;
				prv_addr   = p_q[lupa_pkg::PA_W-1:0];
				prv_wdata  = tail_rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			summ_q <= SB'(lupa_pkg::HAS_AVAIL);
		end else begin
			case (cmd.op)
				lupa_pkg::OP_CLEAR: clr_q <= clr_q + 1'b1;
				lupa_pkg::OP_UNL_WR: begin
					if (both) summ_q[wo_old] <= map_clr != 64'd0;
				end
				lupa_pkg::OP_APP_WR: begin
					if (!bkt_set) summ_q[wo_new] <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			lupa_pkg::OP_ACCEPT: p_q <= req.port_number;
			lupa_pkg::OP_EVAL: begin
				c_old_q <= cnt_rdata;
				c_new_q <= cmd.dec ? cnt_rdata - 1'b1 : cnt_rdata + 1'b1;
			end
			lupa_pkg::OP_SRCH1: begin
				w_q   <= w_pick;
				any_q <= w_any;
			end
			lupa_pkg::OP_SRCH2: mw_q <= mw32[lupa_pkg::MW_W-1:0];
			lupa_pkg::OP_SRCH4: p_q <= any_q ? head_rdata : '0;
			lupa_pkg::OP_DONE: begin
				rsp_q.granted_port   <= p_q;
				rsp_q.status         <= cmd.status;
				rsp_q.took_preferred <= cmd.took;
			end
			default: begin
			end
		endcase
	end

	assign rsp = rsp_q;

	lupa_ram #(.WIDTH(CW), .DEPTH(lupa_pkg::NUM_PORTS)) u_cnt (
		.clk(clk), .en(cnt_en), .we(cnt_we), .addr(cnt_addr),
		.wdata(cnt_wdata), .rdata(cnt_rdata)
	);

	lupa_ram #(.WIDTH(PW), .DEPTH(lupa_pkg::NUM_PORTS)) u_nxt (
		.clk(clk), .en(nxt_en), .we(nxt_we), .addr(nxt_addr),
		.wdata(nxt_wdata), .rdata(nxt_rdata)
	);

	lupa_ram #(.WIDTH(PW), .DEPTH(lupa_pkg::NUM_PORTS)) u_prv (
		.clk(clk), .en(prv_en), .we(prv_we), .addr(prv_addr),
		.wdata(prv_wdata), .rdata(prv_rdata)
	);

	lupa_ram #(.WIDTH(PW), .DEPTH(lupa_pkg::NUM_BUCKETS)) u_head (
		.clk(clk), .en(head_en), .we(head_we), .addr(head_addr),
		.wdata(head_wdata), .rdata(head_rdata)
	);

	lupa_ram #(.WIDTH(PW), .DEPTH(lupa_pkg::NUM_BUCKETS)) u_tail (
		.clk(clk), .en(tail_en), .we(tail_we), .addr(tail_addr),
		.wdata(tail_wdata), .rdata(tail_rdata)
	);

	lupa_ram #(.WIDTH(64), .DEPTH(lupa_pkg::MAP_WORDS)) u_map (
		.clk(clk), .en(map_en), .we(map_we), .addr(map_addr),
		.wdata(map_wdata), .rdata(map_rdata)
	);

endmodule

`default_nettype wire

FILE: hdl/lupa_ctrl.sv
// lupa_ctrl: sequencing state machine and handshake control
// uses lupa_pkg; drives commands into lupa_datapath
`default_nettype none

module lupa_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	input  wire logic [1:0]      req_action,
	input  wire logic            rsp_stall,
	input  wire lupa_pkg::stat_t stat,
	output lupa_pkg::cmd_t       cmd,
	output logic                 req_stall,
	output logic                 rsp_valid
);

	typedef enum logic [14:0] {
		S_CLEAR = 15'b000000000000001,
		S_IDLE  = 15'b000000000000010,
		S_RD    = 15'b000000000000100,
		S_EV    = 15'b000000000001000,
		S_S1    = 15'b000000000010000,
		S_S2    = 15'b000000000100000,
		S_S3    = 15'b000000001000000,
		S_S4    = 15'b000000010000000,
		S_CH    = 15'b000000100000000,
		S_U1    = 15'b000001000000000,
		S_U2    = 15'b000010000000000,
		S_CW    = 15'b000100000000000,
		S_A1    = 15'b001000000000000,
		S_A2    = 15'b010000000000000,
		S_DONE  = 15'b100000000000000
	} state_t;

	state_t            state_q, state_d;
	logic [1:0]        act_q, act_d;
	logic              srch_q, srch_d;
	logic              took_q, took_d;
	lupa_pkg::status_t status_q, status_d;
	logic              rsp_valid_q;

	always_comb begin
		state_d    = state_q;
		act_d      = act_q;
		srch_d     = srch_q;
		took_d     = took_q;
		status_d   = status_q;
		cmd.op     = lupa_pkg::OP_NONE;
		cmd.dec    = 1'b0;
		cmd.status = status_q;
		cmd.took   = took_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = lupa_pkg::OP_CLEAR;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.op   = lupa_pkg::OP_ACCEPT;
					act_d    = req_action;
					srch_d   = 1'b0;
					took_d   = 1'b0;
					status_d = lupa_pkg::ST_OK;
					state_d  = S_RD;
				end
			end
			S_RD: begin
				cmd.op  = lupa_pkg::OP_RD_CNT;
				state_d = S_EV;
			end
			S_EV: begin
				if (act_q == lupa_pkg::ACT_GET && !srch_q) begin
					if (stat.avail && stat.cnt_zero) begin
						cmd.op  = lupa_pkg::OP_EVAL;
						took_d  = 1'b1;
						state_d = S_CH;
					end else begin
						state_d = S_S1;
					end
				end else if (act_q == lupa_pkg::ACT_GET || act_q == lupa_pkg::ACT_ALLOC) begin
					if (!stat.in_range) begin
						state_d = S_DONE;
					end else if (stat.cnt_lim) begin
						status_d = lupa_pkg::ST_LIMIT;
						state_d  = S_DONE;
					end else begin
						cmd.op  = lupa_pkg::OP_EVAL;
						state_d = S_CH;
					end
				end else if (act_q == lupa_pkg::ACT_DEALLOC) begin
					if (!stat.in_range) begin
						state_d = S_DONE;
					end else if (stat.cnt_zero) begin
						status_d = lupa_pkg::ST_ZERO;
						state_d  = S_DONE;
					end else begin
						cmd.op  = lupa_pkg::OP_EVAL;
						cmd.dec = 1'b1;
						state_d = S_CH;
					end
				end else begin
					state_d = S_DONE;
				end
			end
			S_S1: begin
				cmd.op  = lupa_pkg::OP_SRCH1;
				state_d = S_S2;
			end
			S_S2: begin
				cmd.op  = lupa_pkg::OP_SRCH2;
				state_d = S_S3;
			end
			S_S3: begin
				cmd.op  = lupa_pkg::OP_SRCH3;
				state_d = S_S4;
			end
			S_S4: begin
				cmd.op  = lupa_pkg::OP_SRCH4;
				srch_d  = 1'b1;
				state_d = S_RD;
			end
			S_CH: begin
				state_d = stat.unl_need ? S_U1 : S_CW;
			end
			S_U1: begin
				cmd.op  = lupa_pkg::OP_UNL_RD;
				state_d = S_U2;
			end
			S_U2: begin
				cmd.op  = lupa_pkg::OP_UNL_WR;
				state_d = stat.app_need ? S_A1 : S_DONE;
			end
			S_CW: begin
				cmd.op  = lupa_pkg::OP_CNT_WR;
				state_d = stat.app_need ? S_A1 : S_DONE;
			end
			S_A1: begin
				cmd.op  = lupa_pkg::OP_APP_RD;
				state_d = S_A2;
			end
			S_A2: begin
				cmd.op  = lupa_pkg::OP_APP_WR;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.op  = lupa_pkg::OP_DONE;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			act_q       <= '0;
			srch_q      <= 1'b0;
			took_q      <= 1'b0;
			status_q    <= lupa_pkg::ST_OK;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			act_q    <= act_d;
			srch_q   <= srch_d;
			took_q   <= took_d;
			status_q <= status_d;
			if (cmd.op == lupa_pkg::OP_DONE) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;

	a_clear_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> req_stall)
		else $error("input taken during clearing pass");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == lupa_pkg::OP_DONE |=> rsp_valid_q && state_q == S_IDLE)
		else $error("result not presented after completion");

	a_zero_dealloc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EV && act_q == lupa_pkg::ACT_DEALLOC && stat.in_range && stat.cnt_zero)
		|=> (state_q == S_DONE && status_q == lupa_pkg::ST_ZERO))
		else $error("deallocate at zero count not flagged");

endmodule

`default_nettype wire

FILE: hdl/least_used_port_allocator.sv
// least_used_port_allocator: top level joining controller and datapath
// uses lupa_pkg, lupa_ctrl, lupa_datapath (which holds the lupa_ram instances)
//
// usage
//  - request channel (req_valid, req_stall, req): one item carries an action
//    (get with preferred port, allocate, deallocate) and a port number
//  - response channel (rsp_valid, rsp_stall, rsp): exactly one item per
//    request with the granted port, a status code and the took-preferred flag
//  - items are handled one at a time; an allocate, deallocate or direct get
//    runs from accept to result through a chain of dependent single-port
//    memory accesses (refused or flagged items and counts leaving the bucket
//    range skip some of them), a get that falls back to the bucket search
//    first runs the four-step bitmap search for the lowest bucket; the next
//    item is accepted only after the result is loaded
//  - after reset a clearing pass over max(NUM_PORTS, MAP_WORDS) addresses (65536
//    here) initializes counts, links and the bucket bitmap; req_stall stays
//    high meanwhile
//  - the result sits in an output register; while the receiver stalls the
//    next request is still accepted and worked on, and only its completion
//    waits until the register is free
`default_nettype none

module least_used_port_allocator (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire lupa_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output lupa_pkg::rsp_t      rsp
);

	// command and status between sequencer and datapath
	lupa_pkg::cmd_t  cmd;
	lupa_pkg::stat_t stat;

	lupa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_action (req.action),
		.rsp_stall  (rsp_stall),
		.stat       (stat),
		.cmd        (cmd),
		.req_stall  (req_stall),
		.rsp_valid  (rsp_valid)
	);

	// memories, bitmap summary and result register
	lupa_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// testbench: self-checking bench for least_used_port_allocator
// depends on lupa_pkg and the allocator RTL; holds its own bucket model of the allocator
`timescale 1ns / 1ps

module testbench;

	localparam int LIMIT_CYCLES = 3000000;
	localparam int HOLD_CYCLES  = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	lupa_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	lupa_pkg::rsp_t rsp;

	least_used_port_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always #5 clk = ~clk;

	// shadow allocator state
	bit [16:0] use_cnt [0:65535];
	bit [15:0] nxt [0:65535];
	bit [15:0] prv [0:65535];
	bit [15:0] bhead [0:65535];
	bit [15:0] btail [0:65535];
	bit [63:0] bmap [0:1023];

	lupa_pkg::req_t pending_items [$];
	lupa_pkg::rsp_t expected_rsps [$];
	int errors = 0;
	int n_sent = 0;
	int cycles = 0;
	bit no_idle = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	function automatic bit bucket_busy(int b);
		return bmap[b >> 6][b & 63];
	endfunction

	task automatic unlink_port(int p, int b);
		bit [15:0] nx, pv;
		bit hd, tl;
		nx = nxt[p];
		pv = prv[p];
		hd = (bhead[b] == p);
		tl = (btail[b] == p);
		if (hd && tl) begin
			bmap[b >> 6][b & 63] = 1'b0;
			return;
		end
		if (hd) bhead[b] = nx;
		else nxt[pv] = nx;
		if (tl) btail[b] = pv;
		else prv[nx] = pv;
	endtask

	task automatic append_port(int p, int b);
		if (!bucket_busy(b)) begin
			bhead[b] = 16'(p);
			btail[b] = 16'(p);
			bmap[b >> 6][b & 63] = 1'b1;
		end else begin
			nxt[btail[b]] = 16'(p);
			prv[p] = btail[b];
			btail[b] = 16'(p);
		end
	endtask

	task automatic move_count(int p, int c_new);
		int c_old;
		c_old = int'(use_cnt[p]);
		if (p >= lupa_pkg::DYNAMIC_BASE && c_old <= lupa_pkg::MAX_BUCKET)
			unlink_port(p, c_old);
		use_cnt[p] = 17'(c_new);
		if (p >= lupa_pkg::DYNAMIC_BASE && c_new <= lupa_pkg::MAX_BUCKET)
			append_port(p, c_new);
	endtask

	task automatic bump_port(int p, output lupa_pkg::status_t st);
		if (use_cnt[p] == lupa_pkg::COUNT_LIMIT) begin
			st = lupa_pkg::ST_LIMIT;
		end else begin
			move_count(p, int'(use_cnt[p]) + 1);
			st = lupa_pkg::ST_OK;
		end
	endtask

	task automatic reset_shadow();
		for (int p = 0; p < 65536; p++) begin
			use_cnt[p] = '0;
			nxt[p] = '0;
			prv[p] = '0;
			bhead[p] = '0;
			btail[p] = '0;
		end
		for (int w = 0; w < 1024; w++) bmap[w] = '0;
		for (int p = lupa_pkg::DYNAMIC_BASE; p < lupa_pkg::NUM_PORTS; p++) append_port(p, 0);
	endtask

	// expected response for one request, updating the shadow state
	task automatic predict_grant(lupa_pkg::req_t r, output lupa_pkg::rsp_t o);
		lupa_pkg::status_t st;
		int p, g;
		bit found;
		p = int'(r.port_number);
		o.granted_port = r.port_number;
		o.status = lupa_pkg::ST_OK;
		o.took_preferred = 1'b0;
		case (r.action)
			lupa_pkg::ACT_GET: begin
				if (p >= lupa_pkg::DYNAMIC_BASE && use_cnt[p] == 0) begin
					bump_port(p, st);
					o.took_preferred = 1'b1;
				end else begin
					g = 0;
					found = 1'b0;
					for (int w = 0; w < 1024 && !found; w++) begin
						if (bmap[w] != 0) begin
							for (int i = 0; i < 64 && !found; i++) begin
								if (bmap[w][i]) begin
									g = int'(bhead[w * 64 + i]);
									found = 1'b1;
								end
							end
						end
					end
					o.granted_port = 16'(g);
					bump_port(g, st);
				end
				o.status = st;
			end
			lupa_pkg::ACT_ALLOC: begin
				bump_port(p, st);
				o.status = st;
			end
			lupa_pkg::ACT_DEALLOC: begin
				if (use_cnt[p] == 0) o.status = lupa_pkg::ST_ZERO;
				else move_count(p, int'(use_cnt[p]) - 1);
			end
			default: ;
		endcase
	endtask

	function automatic lupa_pkg::req_t random_item();
		lupa_pkg::req_t r;
		int a, k;
		a = $urandom_range(99);
		if (a < 40) r.action = lupa_pkg::ACT_GET;
		else if (a < 72) r.action = lupa_pkg::ACT_ALLOC;
		else if (a < 95) r.action = lupa_pkg::ACT_DEALLOC;
		else r.action = lupa_pkg::ACT_RSVD;
		k = $urandom_range(99);
		// small pool of dynamic ports keeps buckets busy and reused
		if (k < 60) r.port_number = 16'(lupa_pkg::DYNAMIC_BASE + $urandom_range(15));
		else if (k < 75) r.port_number = 16'($urandom_range(lupa_pkg::DYNAMIC_BASE - 1));
		else if (k < 90) r.port_number = 16'($urandom);
		else begin
			case ($urandom_range(3))
				0: r.port_number = 16'h0000;
				1: r.port_number = 16'h7FFF;
				2: r.port_number = 16'h8000;
				default: r.port_number = 16'hFFFF;
			endcase
		end
		return r;
	endfunction

	function automatic lupa_pkg::req_t mk(logic [1:0] a, logic [15:0] p);
		lupa_pkg::req_t r;
		r.action = a;
		r.port_number = p;
		return r;
	endfunction

	// sender: one payload change per edge, held while stalled
	always @(posedge clk) begin
		lupa_pkg::rsp_t e;
		if (arst_n) begin
			if (!req_valid || !req_stall) begin
				if (req_valid) begin
					predict_grant(req, e);
					expected_rsps.push_back(e);
					n_sent <= n_sent + 1;
				end
				if (pending_items.size() != 0 && (no_idle || $urandom_range(99) >= 24)) begin
					req <= pending_items.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each item against the oldest expectation
	always @(posedge clk) begin
		lupa_pkg::rsp_t e;
		if (rsp_valid && !rsp_stall) begin
			if (expected_rsps.size() == 0) begin
				$display("%0t: unexpected item exp none act %h", $time, rsp);
				errors++;
			end else begin
				e = expected_rsps.pop_front();
				if (rsp.granted_port !== e.granted_port) begin
					$display("%0t: granted_port exp %h act %h", $time,
						e.granted_port, rsp.granted_port);
					errors++;
				end
				if (rsp.status !== e.status) begin
					$display("%0t: status exp %h act %h", $time, e.status, rsp.status);
					errors++;
				end
				if (rsp.took_preferred !== e.took_preferred) begin
					$display("%0t: took_preferred exp %b act %b", $time,
						e.took_preferred, rsp.took_preferred);
					errors++;
				end
			end
		end
		// one long hold-off so the block fills and stalls its input
		if (!hold_done && n_sent >= 500) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= !no_idle && ($urandom_range(99) < 24);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_items.size() != 0 || req_valid || expected_rsps.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		reset_shadow();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, each action, zero-count deallocate, fallback search
		pending_items.push_back(mk(lupa_pkg::ACT_GET, 16'h8000));
		pending_items.push_back(mk(lupa_pkg::ACT_GET, 16'h8000));
		pending_items.push_back(mk(lupa_pkg::ACT_ALLOC, 16'hFFFF));
		pending_items.push_back(mk(lupa_pkg::ACT_GET, 16'hFFFF));
		pending_items.push_back(mk(lupa_pkg::ACT_DEALLOC, 16'hFFFF));
		pending_items.push_back(mk(lupa_pkg::ACT_DEALLOC, 16'hFFFF));
		pending_items.push_back(mk(lupa_pkg::ACT_GET, 16'hFFFF));
		pending_items.push_back(mk(lupa_pkg::ACT_DEALLOC, 16'h0000));
		pending_items.push_back(mk(lupa_pkg::ACT_ALLOC, 16'h0000));
		pending_items.push_back(mk(lupa_pkg::ACT_GET, 16'h0000));
		pending_items.push_back(mk(lupa_pkg::ACT_DEALLOC, 16'h0000));
		pending_items.push_back(mk(lupa_pkg::ACT_GET, 16'h7FFF));
		pending_items.push_back(mk(lupa_pkg::ACT_ALLOC, 16'h7FFF));
		pending_items.push_back(mk(lupa_pkg::ACT_DEALLOC, 16'h7FFF));
		pending_items.push_back(mk(lupa_pkg::ACT_RSVD, 16'hFFFF));
		pending_items.push_back(mk(lupa_pkg::ACT_RSVD, 16'h0000));
		pending_items.push_back(mk(lupa_pkg::ACT_ALLOC, 16'h8000));
		pending_items.push_back(mk(lupa_pkg::ACT_ALLOC, 16'h8000));
		pending_items.push_back(mk(lupa_pkg::ACT_DEALLOC, 16'h8000));
		pending_items.push_back(mk(lupa_pkg::ACT_DEALLOC, 16'h8001));
		pending_items.push_back(mk(lupa_pkg::ACT_GET, 16'h8001));
		pending_items.push_back(mk(lupa_pkg::ACT_GET, 16'h5555));
		pending_items.push_back(mk(lupa_pkg::ACT_ALLOC, 16'hAAAA));
		pending_items.push_back(mk(lupa_pkg::ACT_GET, 16'hAAAA));
		wait_drained();

		// random phases; the sender pauses between them until all items are back
		for (int i = 0; i < 400; i++) pending_items.push_back(random_item());
		wait_drained();
		no_idle <= 1'b1;
		for (int i = 0; i < 400; i++) pending_items.push_back(random_item());
		wait_drained();
		no_idle <= 1'b0;
		for (int i = 0; i < 400; i++) pending_items.push_back(random_item());
		wait_drained();

		if (errors == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
